// ----- rtl/core/mpq_pkg.sv -----
package mpq_pkg;

	typedef enum logic {
		KIND_INSERT  = 1'b0,
		KIND_EXTRACT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_EXTRACTED = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_UNDERFLOW = 2'd3
	} status_t;

	localparam int ValueW = 32;
	localparam int PrioW  = 16;
	localparam int CountW = 5;

	typedef struct packed {
		kind_t                     kind;
		logic signed [ValueW-1:0]  item_value;
		logic signed [PrioW-1:0]   item_priority;
	} cmd_t;

	typedef struct packed {
		status_t                   status;
		logic signed [ValueW-1:0]  out_value;
		logic signed [PrioW-1:0]   out_priority;
		logic [CountW-1:0]         count;
	} rsp_t;

	// one slot of the sorted chain
	typedef struct packed {
		logic              valid;
		logic [ValueW-1:0] value;
		logic [PrioW-1:0]  prio;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic              insert;
		logic              extract;
		logic [ValueW-1:0] value;
		logic [PrioW-1:0]  prio;
	} cell_op_t;

endpackage

// ----- rtl/core/mpq_stream_if.sv -----
interface mpq_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/min_priority_queue.sv -----
// Bounded min-priority queue built as a sorted chain of CAPACITY cells. Slot 0
// always holds the lowest priority (earliest arrival among equals). An insert
// compares the new priority in every cell at once and the tail shifts down one
// slot; an extract pops slot 0 and the whole chain shifts up. One operation is
// accepted every clock, and its result word is registered and shows up in the
// cycle after acceptance; a stalled result only blocks input while it is not
// taken. No clearing pass after reset: cells come up empty.
module min_priority_queue import mpq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic          clk,
	input logic          arst_n,
	mpq_stream_if.sink   cmd,
	mpq_stream_if.source res
);

	localparam int OccW = $clog2(CAPACITY + 1);

	entry_t   chain [CAPACITY];
	logic     place [CAPACITY];
	cell_op_t op;

	logic            fire;
	logic            is_ins;
	logic            full;
	logic            empty;
	logic [OccW-1:0] occ_q;
	logic [OccW-1:0] occ_d;
	logic [OccW+4:0] occ_ext;
	logic            res_valid_q;
	rsp_t            res_data_q;
	rsp_t            res_d;

	assign cmd.ready = !res_valid_q || res.ready;
	assign fire      = cmd.valid && cmd.ready;
	assign is_ins    = (cmd.data.kind == KIND_INSERT);
	assign full      = chain[CAPACITY-1].valid;
	assign empty     = !chain[0].valid;

	assign op.insert  = fire && is_ins && !full;
	assign op.extract = fire && !is_ins && !empty;
	assign op.value   = cmd.data.item_value;
	assign op.prio    = cmd.data.item_priority;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_p;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_p = 1'b0;
		end else begin : g_body
			assign left_e = chain[i-1];
			assign left_p = place[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_mid
			assign right_e = chain[i+1];
		end

		mpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.left      (left_e),
			.right     (right_e),
			.left_place(left_p),
			.place     (place[i]),
			.entry     (chain[i])
		);
	end

	always_comb begin
		occ_d = occ_q;
		if (op.insert) begin
			occ_d = occ_q + OccW'(1);
		end else if (op.extract) begin
			occ_d = occ_q - OccW'(1);
		end
	end

	// count is the occupancy modulo 32
	assign occ_ext = (OccW + 5)'(occ_d);

	always_comb begin
		res_d              = '0;
		res_d.count        = occ_ext[CountW-1:0];
		if (is_ins) begin
			res_d.status = full ? ST_OVERFLOW : ST_INSERTED;
		end else if (empty) begin
			res_d.status = ST_UNDERFLOW;
		end else begin
			res_d.status       = ST_EXTRACTED;
			res_d.out_value    = chain[0].value;
			res_d.out_priority = chain[0].prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_data_q <= res_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

endmodule

// ----- rtl/core/mpq_cell.sv -----
module mpq_cell import mpq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  entry_t   left,
	input  entry_t   right,
	input  logic     left_place,
	output logic     place,
	output entry_t   entry
);

	entry_t entry_q;
	entry_t entry_d;
	logic   load;

	// new word belongs at or before this slot; strict compare keeps equal
	// priorities in arrival order
	assign place = !entry_q.valid || ($signed(op.prio) < $signed(entry_q.prio));

	always_comb begin
		load    = 1'b0;
		entry_d = entry_q;
		if (op.insert && place) begin
			load = 1'b1;
			if (left_place) begin
				entry_d = left;
			end else begin
				entry_d = '{valid: 1'b1, value: op.value, prio: op.prio};
			end
		end else if (op.extract) begin
			load    = 1'b1;
			entry_d = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (load) begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

// ----- rtl/core/mpq_checker.sv -----
module mpq_checker import mpq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input rsp_t res_data
);

	localparam int CapW = $clog2(CAPACITY + 1) + 5;
	localparam logic [CapW-1:0] CapFull = CapW'(CAPACITY);

	// held result word must not change
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_res_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> res_valid)
		else $error("accepted word produced no result");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status != ST_EXTRACTED) |->
			(res_data.out_value == '0) && (res_data.out_priority == '0))
		else $error("nonzero payload on non-extract result");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == ST_UNDERFLOW) |-> res_data.count == '0)
		else $error("underflow with entries held");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == ST_OVERFLOW) |->
			res_data.count == CapFull[CountW-1:0])
		else $error("overflow below capacity");

endmodule

bind min_priority_queue mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_data (res.data)
);
